// ===== rtl/dup_pkg.sv =====
package dup_pkg;

    // fixed field widths
    localparam int CHAR_W   = 8;
    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 2;

    // default accumulator width
    localparam int VALUE_BITS_DEF = 64;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FMT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // character classes handed from front to back
    typedef enum logic [2:0] {
        CL_SPACE,
        CL_PLUS,
        CL_MINUS,
        CL_DIGIT,
        CL_OTHER,
        CL_TERM
    } char_class_t;

    // one queued transaction: class and digit value
    typedef struct packed {
        char_class_t cls;
        logic [3:0]  digit;
    } dup_item_t;

    // parser phase, one-hot
    typedef enum logic [4:0] {
        PH_LEAD  = 5'b00001,
        PH_SIGN  = 5'b00010,
        PH_DIGIT = 5'b00100,
        PH_TRAIL = 5'b01000,
        PH_BAD   = 5'b10000
    } phase_t;

endpackage

// ===== rtl/dup_front.sv =====
module dup_front (
    input  logic [dup_pkg::CHAR_W-1:0] char_in,
    output dup_pkg::dup_item_t         item
);
    import dup_pkg::*;

    logic is_space;
    logic is_digit;

    // classify one character
    assign is_space = (char_in == 8'h20) || ((char_in >= 8'h09) && (char_in <= 8'h0D));
    assign is_digit = (char_in >= 8'h30) && (char_in <= 8'h39);

    always_comb begin
        item.digit = char_in[3:0];
        if (char_in == 8'h00) begin
            item.cls = CL_TERM;
        end else if (is_space) begin
            item.cls = CL_SPACE;
        end else if (char_in == 8'h2B) begin
            item.cls = CL_PLUS;
        end else if (char_in == 8'h2D) begin
            item.cls = CL_MINUS;
        end else if (is_digit) begin
            item.cls = CL_DIGIT;
        end else begin
            item.cls = CL_OTHER;
        end
    end

endmodule

// ===== rtl/dup_queue.sv =====
module dup_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  dup_pkg::dup_item_t push_item,
    output logic               not_full,
    input  logic               pop,
    output dup_pkg::dup_item_t pop_item,
    output logic               not_empty
);
    import dup_pkg::*;

    dup_item_t  entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign not_full  = (count_reg != 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_item  = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/dup_back.sv =====
module dup_back #(
    parameter int VALUE_BITS = dup_pkg::VALUE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_valid,
    input  dup_pkg::dup_item_t           q_item,
    output logic                         q_pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [dup_pkg::VALUE_W-1:0]  m_value,
    output logic [dup_pkg::STATUS_W-1:0] m_status
);
    import dup_pkg::*;

    localparam int WIDE_W = VALUE_BITS + 4;

    phase_t                  phase_reg, phase_next;
    logic [VALUE_BITS-1:0]   acc_reg, acc_next;
    logic                    neg_reg, neg_next;
    logic                    ovf_reg, ovf_next;
    logic                    m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0]      m_value_reg, m_value_next;
    logic [STATUS_W-1:0]     m_status_reg, m_status_next;

    logic                    is_term;
    logic                    out_free;
    logic [WIDE_W-1:0]       acc_wide;
    logic [WIDE_W-1:0]       acc_x10;
    logic                    too_big;

    assign m_valid  = m_valid_reg;
    assign m_value  = m_value_reg;
    assign m_status = m_status_reg;

    // a terminator waits for the output register, other characters never stall
    assign is_term  = (q_item.cls == CL_TERM);
    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = q_valid && (!is_term || out_free);

    // acc * 10 + digit, carry bits above the value width mean overflow
    assign acc_wide = WIDE_W'(acc_reg);
    assign acc_x10  = (acc_wide << 3) + (acc_wide << 1) + WIDE_W'(q_item.digit);
    assign too_big  = |acc_x10[WIDE_W-1:VALUE_BITS];

    // phase and accumulator update
    always_comb begin
        phase_next    = phase_reg;
        acc_next      = acc_reg;
        neg_next      = neg_reg;
        ovf_next      = ovf_reg;
        m_value_next  = m_value_reg;
        m_status_next = m_status_reg;
        m_valid_next  = m_valid_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (q_pop) begin
            if (is_term) begin
                // finish the string and return to the start state
                m_valid_next  = 1'b1;
                m_value_next  = '0;
                if ((phase_reg == PH_DIGIT) || (phase_reg == PH_TRAIL)) begin
                    if (ovf_reg || (neg_reg && (acc_reg != '0))) begin
                        m_status_next = ST_RANGE;
                    end else begin
                        m_status_next = ST_OK;
                        m_value_next  = VALUE_W'(acc_reg);
                    end
                end else begin
                    m_status_next = ST_FMT;
                end
                phase_next = PH_LEAD;
                acc_next   = '0;
                neg_next   = 1'b0;
                ovf_next   = 1'b0;
            end else begin
                case (phase_reg)
                    PH_LEAD: begin
                        if (q_item.cls == CL_SPACE) begin
                            phase_next = PH_LEAD;
                        end else if ((q_item.cls == CL_PLUS) || (q_item.cls == CL_MINUS)) begin
                            neg_next   = (q_item.cls == CL_MINUS);
                            phase_next = PH_SIGN;
                        end else if (q_item.cls == CL_DIGIT) begin
                            phase_next = PH_DIGIT;
                        end else begin
                            phase_next = PH_BAD;
                        end
                    end
                    PH_SIGN: begin
                        phase_next = (q_item.cls == CL_DIGIT) ? PH_DIGIT : PH_BAD;
                    end
                    PH_DIGIT: begin
                        if (q_item.cls == CL_SPACE) begin
                            phase_next = PH_TRAIL;
                        end else if (q_item.cls != CL_DIGIT) begin
                            phase_next = PH_BAD;
                        end
                    end
                    PH_TRAIL: begin
                        if (q_item.cls != CL_SPACE) begin
                            phase_next = PH_BAD;
                        end
                    end
                    default: begin
                        phase_next = PH_BAD;
                    end
                endcase

                // digit accumulation in the phases that take a digit
                if ((q_item.cls == CL_DIGIT) && !ovf_reg &&
                    ((phase_reg == PH_LEAD) || (phase_reg == PH_SIGN) ||
                     (phase_reg == PH_DIGIT))) begin
                    if (too_big) begin
                        ovf_next = 1'b1;
                    end else begin
                        acc_next = acc_x10[VALUE_BITS-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_LEAD;
            acc_reg     <= '0;
            neg_reg     <= 1'b0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            acc_reg     <= acc_next;
            neg_reg     <= neg_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
    end

endmodule

// ===== rtl/decimal_unsigned_parser_top.sv =====
// Decimal string parser: one ASCII character per transaction on s_char_in, a zero byte ends
// the string and yields one result (m_value, m_status: 0 ok, 1 format error, 2 out of range;
// m_value is zero unless ok). Leading whitespace, an optional sign, digits and trailing
// whitespace are accepted; minus zero is ok. A new character is taken every cycle while the
// queue has room: the front classifies it into a two-entry queue and the back applies the
// multiply-by-ten-and-add of VALUE_BITS + 4 bits per character. The result register is loaded as
// the back pops the terminator; only a terminator meeting a result not yet taken stalls the back.
module decimal_unsigned_parser_top #(
    parameter int VALUE_BITS = dup_pkg::VALUE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [dup_pkg::CHAR_W-1:0]   s_char_in,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [dup_pkg::VALUE_W-1:0]  m_value,
    output logic [dup_pkg::STATUS_W-1:0] m_status
);
    import dup_pkg::*;

    dup_item_t front_item;
    dup_item_t q_item;
    logic      q_not_full;
    logic      q_valid;
    logic      q_pop;
    logic      s_accept;

    assign s_ready  = q_not_full;
    assign s_accept = s_valid && q_not_full;

    // classification front
    dup_front u_front (
        .char_in (s_char_in),
        .item    (front_item)
    );

    // decoupling queue
    dup_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_accept),
        .push_item (front_item),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .pop_item  (q_item),
        .not_empty (q_valid)
    );

    // parsing back end and result register
    dup_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_value  (m_value),
        .m_status (m_status)
    );

    // checks
    a_err_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ST_OK)) |-> (m_value == '0))
        else $error("nonzero value with error status");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_status == ST_OK) || (m_status == ST_FMT) || (m_status == ST_RANGE)))
        else $error("undefined status code");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_push_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> q_valid)
        else $error("accepted transaction missing from queue");

endmodule

// ===== tb/sv/tb_decimal_unsigned_parser_top.sv =====
`timescale 1ns / 1ps

module tb_decimal_unsigned_parser_top;

    import dup_pkg::*;

    localparam int          VB          = VALUE_BITS_DEF;
    localparam logic [63:0] VMAX        = {64{1'b1}} >> (64 - VB);
    localparam int          CHAR_TARGET = 1850;
    localparam int          CYCLE_LIMIT = 600000;
    localparam int          HOLD_LEN    = 300;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_HIGH  = 8'hFF;

    typedef struct {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
    } parse_result_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [CHAR_W-1:0]   s_char_in;
    logic                m_valid;
    logic                m_ready;
    logic [VALUE_W-1:0]  m_value;
    logic [STATUS_W-1:0] m_status;

    // parser state mirror
    phase_t      ph       = PH_LEAD;
    logic [63:0] acc      = '0;
    logic        neg      = 1'b0;
    logic        ovf      = 1'b0;

    parse_result_t pending_results[$];
    logic [7:0]    text_q[$];
    int            chars_sent  = 0;
    int            error_count = 0;
    int            cycle_count = 0;
    int            hold_cycles = 0;
    bit            idle_on     = 1'b1;

    decimal_unsigned_parser_top #(
        .VALUE_BITS(VB)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_char_in(s_char_in),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_value  (m_value),
        .m_status (m_status)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // character classes
    function automatic bit is_ws(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_dig(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // multiply by ten and add, latching overflow
    function automatic void accumulate(input logic [7:0] c);
        logic [63:0] d;
        d = {56'd0, c - CH_ZERO};
        if (ovf)
            return;
        if (acc > (VMAX - d) / 64'd10)
            ovf = 1'b1;
        else
            acc = acc * 64'd10 + d;
    endfunction

    // advance the parser by one character, queue a result on the terminator
    function automatic void parse_char(input logic [7:0] c);
        parse_result_t r;
        if (c == CH_NUL) begin
            r.value  = '0;
            r.status = ST_FMT;
            if (ph == PH_DIGIT || ph == PH_TRAIL) begin
                if (ovf || (neg && acc != 0)) begin
                    r.status = ST_RANGE;
                end else begin
                    r.status = ST_OK;
                    r.value  = acc;
                end
            end
            pending_results.push_back(r);
            ph  = PH_LEAD;
            acc = '0;
            neg = 1'b0;
            ovf = 1'b0;
            return;
        end
        case (ph)
            PH_LEAD: begin
                if (is_ws(c)) begin
                end else if (c == CH_PLUS || c == CH_MINUS) begin
                    neg = (c == CH_MINUS);
                    ph  = PH_SIGN;
                end else if (is_dig(c)) begin
                    accumulate(c);
                    ph = PH_DIGIT;
                end else begin
                    ph = PH_BAD;
                end
            end
            PH_SIGN: begin
                if (is_dig(c)) begin
                    accumulate(c);
                    ph = PH_DIGIT;
                end else begin
                    ph = PH_BAD;
                end
            end
            PH_DIGIT: begin
                if (is_dig(c))
                    accumulate(c);
                else if (is_ws(c))
                    ph = PH_TRAIL;
                else
                    ph = PH_BAD;
            end
            PH_TRAIL: begin
                if (!is_ws(c))
                    ph = PH_BAD;
            end
            default: ph = PH_BAD;
        endcase
    endfunction

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_ws();
        int r;
        r = $urandom_range(0, 6);
        return (r > 4) ? CH_SPACE : CH_TAB + 8'(r);
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endfunction

    function automatic void add_digit_char(input int lo, input int hi);
        text_q.push_back(CH_ZERO + 8'($urandom_range(lo, hi)));
    endfunction

    // decimal digits of v, most significant first
    function automatic void add_dec(input logic [63:0] v);
        logic [7:0] tmp[$];
        tmp = {};
        do begin
            tmp.push_front(CH_ZERO + 8'(v % 64'd10));
            v = v / 64'd10;
        end while (v != 0);
        foreach (tmp[i])
            text_q.push_back(tmp[i]);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                   input logic [63:0] got_v);
        $display("mismatch at cycle %0d: %s expected %0d got %0d",
                 cycle_count, what, exp_v, got_v);
        error_count++;
    endtask

    // one character transaction on the input channel
    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid   <= 1'b0;
            s_char_in <= 8'($urandom);
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_char_in <= c;
        do @(posedge aclk); while (!s_ready);
        parse_char(c);
        chars_sent++;
    endtask

    task automatic send_text();
        while (text_q.size() > 0)
            send_char(text_q.pop_front());
    endtask

    // stop offering and let every outstanding result come back
    task automatic sender_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // random string: mostly well formed, some corrupted, some plain noise
    task automatic build_random_string();
        int r;
        int n;
        int base;
        r = $urandom_range(0, 99);
        if (r >= 88) begin
            n = $urandom_range(1, 8);
            repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
            text_q.push_back(CH_NUL);
            return;
        end
        base = text_q.size();
        repeat ($urandom_range(0, 3)) text_q.push_back(pick_ws());
        case ($urandom_range(0, 3))
            0: text_q.push_back(CH_PLUS);
            1: text_q.push_back(CH_MINUS);
            default: ;
        endcase
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 4)) text_q.push_back(CH_ZERO);
        n = $urandom_range(0, 99);
        n = (n < 75) ? $urandom_range(1, 6) : (n < 93) ? $urandom_range(7, 19)
                                                       : $urandom_range(20, 24);
        repeat (n) add_digit_char(0, 9);
        repeat ($urandom_range(0, 2)) text_q.push_back(pick_ws());
        if (r >= 70)
            text_q[$urandom_range(base, text_q.size() - 1)] = 8'($urandom_range(1, 255));
        text_q.push_back(CH_NUL);
    endtask

    // empty, whitespace, signs, minus zero, stray characters, high byte
    task automatic test_directed();
        text_q.push_back(CH_NUL);
        add_text(" \t");   text_q.push_back(CH_NUL);
        add_text("+ ");    text_q.push_back(CH_NUL);
        add_text("-0");    text_q.push_back(CH_NUL);
        add_text("-5");    text_q.push_back(CH_NUL);
        add_text("+-1");   text_q.push_back(CH_NUL);
        add_text("7 x");   text_q.push_back(CH_NUL);
        add_text("3-");    text_q.push_back(CH_NUL);
        text_q.push_back(CH_HIGH);
        text_q.push_back(CH_NUL);
        add_text("9 ");    text_q.push_back(CH_NUL);
        send_text();
    endtask

    // values around the top of the range, with random signs and padding
    task automatic test_range_edges();
        repeat (25) begin
            case ($urandom_range(0, 5))
                0: text_q.push_back(CH_MINUS);
                1: text_q.push_back(CH_PLUS);
                default: ;
            endcase
            case ($urandom_range(0, 5))
                0: add_dec(VMAX);
                1: add_dec(VMAX - 64'($urandom_range(0, 1000)));
                2: begin
                    add_dec(VMAX);
                    text_q[text_q.size() - 1] = CH_ZERO + 8'($urandom_range(6, 9));
                end
                3: begin
                    add_dec(VMAX / 64'd10);
                    add_digit_char(0, 9);
                end
                4: begin
                    repeat ($urandom_range(0, 5)) text_q.push_back(CH_ZERO);
                    add_dec({$urandom, $urandom});
                end
                default: begin
                    add_digit_char(1, 9);
                    repeat ($urandom_range(20, 23)) add_digit_char(0, 9);
                end
            endcase
            if ($urandom_range(0, 3) == 0)
                text_q.push_back(pick_ws());
            text_q.push_back(CH_NUL);
            send_text();
        end
    endtask

    // no idling on either side
    task automatic test_back_to_back();
        idle_on = 1'b0;
        repeat (20) begin
            build_random_string();
            send_text();
        end
        idle_on = 1'b1;
    endtask

    // receiver holds off while short strings keep coming, so the input stalls
    task automatic test_output_hold();
        hold_cycles = HOLD_LEN;
        repeat (30) begin
            add_digit_char(0, 9);
            text_q.push_back(CH_NUL);
            send_text();
        end
    endtask

    // sender waits for every result before going on
    task automatic test_drain_pause();
        repeat (10) begin
            build_random_string();
            send_text();
        end
        sender_drain();
        repeat (10) begin
            build_random_string();
            send_text();
        end
    endtask

    task automatic test_random();
        while (chars_sent < CHAR_TARGET) begin
            build_random_string();
            send_text();
        end
    endtask

    // receiver ready with random stalls and the occasional long hold
    initial begin
        int rx_gap;
        rx_gap  = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles--;
            end else if (rx_gap > 0) begin
                m_ready <= 1'b0;
                rx_gap--;
            end else begin
                m_ready <= 1'b1;
                rx_gap = pick_gap();
            end
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        parse_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, value", '0, m_value);
            end else begin
                exp_r = pending_results.pop_front();
                if (m_value !== exp_r.value)
                    report_mismatch("value", exp_r.value, m_value);
                if (m_status !== exp_r.status)
                    report_mismatch("status", 64'(exp_r.status), 64'(m_status));
            end
        end
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_char_in = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_range_edges();
        test_back_to_back();
        test_output_hold();
        test_drain_pause();
        test_random();

        // let the last results out, then a short tail for strays
        sender_drain();
        repeat (20) @(posedge aclk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
